### rtl/nor_flash_array_model_assert.svh
// Assertion macros for the NOR flash array model.
// Included by the top level; no other dependencies.
`ifndef NOR_FLASH_ARRAY_MODEL_ASSERT_SVH
`define NOR_FLASH_ARRAY_MODEL_ASSERT_SVH
`ifndef SYNTHESIS
`define NFA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfa same-cycle check failed");
`define NFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nfa next-cycle check failed");
`else
`define NFA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define NFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/nfa_pkg.sv
// Shared constants, action codes and control structs of the NOR flash array model.
// No dependencies.
package nfa_pkg;

    localparam int unsigned FLASH_BYTES     = 65536;
    localparam int unsigned SECTOR_BYTES    = 16384;
    localparam int unsigned SUBSECTOR_BYTES = 4096;

    localparam int unsigned ADDR_W       = $clog2(FLASH_BYTES);
    localparam int unsigned SUB_COUNT    = FLASH_BYTES / SUBSECTOR_BYTES;
    localparam int unsigned SECTOR_COUNT = FLASH_BYTES / SECTOR_BYTES;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FLASH_BYTES - 1);

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        ACT_READ         = 3'd0,
        ACT_PROGRAM      = 3'd1,
        ACT_ERASE_SUB    = 3'd2,
        ACT_ERASE_SECTOR = 3'd3,
        ACT_ERASE_BULK   = 3'd4
    } action_t;

    // Single-port array access issued by the controller.
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } ram_req_t;

    // Controller status seen by the top level.
    typedef struct packed {
        logic clearing;
        logic walking;
    } stat_t;

endpackage

### rtl/nfa_req_if.sv
// Request channel of the NOR flash array model: valid/ready plus one action beat.
// No dependencies.
interface nfa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [23:0] address;
    logic [15:0] block_number;
    logic [7:0]  data;
    logic        burst_last;

    modport source (output valid, action, address, block_number, data, burst_last,
                    input ready);
    modport sink   (input valid, action, address, block_number, data, burst_last,
                    output ready);
endinterface

### rtl/nfa_rsp_if.sv
// Response channel of the NOR flash array model: valid/ready plus one result beat.
// No dependencies.
interface nfa_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       status;
    logic       last;

    modport source (output valid, read_data, status, last, input ready);
    modport sink   (input valid, read_data, status, last, output ready);
endinterface

### rtl/nfa_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module nfa_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/nfa_ctrl.sv
// Sequencer of the NOR flash array model: decode, read-modify-write, erase walk,
// clearing pass and the result register. Depends on nfa_pkg, nfa_req_if, nfa_rsp_if.
module nfa_ctrl
    import nfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    nfa_req_if.sink     req,
    nfa_rsp_if.source   rsp,
    output ram_req_t    ram_req,
    input  logic [7:0]  ram_rdata,
    output stat_t       stat
);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_READ   = 5'b00100,
        ST_ERASE  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0]        data_reg, data_next;
    logic              is_prog_reg, is_prog_next;
    logic              pend_status_reg, pend_status_next;
    logic              pend_last_reg, pend_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_rd_reg, out_rd_next;
    logic              out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic        out_free;
    logic        addr_ok;
    logic        sub_ok;
    logic        sec_ok;
    logic [31:0] sub_start, sub_end;
    logic [31:0] sec_start, sec_end;

    assign out_free = !out_valid_reg || rsp.ready;
    assign addr_ok  = 32'(req.address) < FLASH_BYTES;
    assign sub_ok   = 32'(req.block_number) < SUB_COUNT;
    assign sec_ok   = 32'(req.block_number) < SECTOR_COUNT;

    // region bounds, clamped at the end of the array
    always_comb
    begin
        sub_start = 32'(req.block_number) * SUBSECTOR_BYTES;
        sub_end   = sub_start + SUBSECTOR_BYTES;
        if (sub_end > FLASH_BYTES)
        begin
            sub_end = FLASH_BYTES;
        end
        sec_start = 32'(req.block_number) * SECTOR_BYTES;
        sec_end   = sec_start + SECTOR_BYTES;
        if (sec_end > FLASH_BYTES)
        begin
            sec_end = FLASH_BYTES;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        end_next         = end_reg;
        addr_next        = addr_reg;
        data_next        = data_reg;
        is_prog_next     = is_prog_reg;
        pend_status_next = pend_status_reg;
        pend_last_next   = pend_last_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_rd_next      = out_rd_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        ram_req          = '0;
        ram_req.addr     = ptr_reg;
        ram_req.wdata    = ERASED_BYTE;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_req.we = 1'b1;
                if (ptr_reg == LAST_ADDR)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    pend_last_next   = req.burst_last;
                    pend_status_next = 1'b0;
                    state_next       = ST_RESULT;
                    unique case (action_t'(req.action))
                        ACT_READ, ACT_PROGRAM:
                        begin
                            if (addr_ok)
                            begin
                                ram_req.re   = 1'b1;
                                ram_req.addr = req.address[ADDR_W-1:0];
                                addr_next    = req.address[ADDR_W-1:0];
                                data_next    = req.data;
                                is_prog_next = (action_t'(req.action) == ACT_PROGRAM);
                                state_next   = ST_READ;
                            end
                            else
                            begin
                                pend_status_next = 1'b1;
                            end
                        end
                        ACT_ERASE_SUB:
                        begin
                            if (sub_ok)
                            begin
                                ptr_next   = sub_start[ADDR_W-1:0];
                                end_next   = ADDR_W'(sub_end - 32'd1);
                                state_next = ST_ERASE;
                            end
                            else
                            begin
                                pend_status_next = 1'b1;
                            end
                        end
                        ACT_ERASE_SECTOR:
                        begin
                            if (sec_ok)
                            begin
                                ptr_next   = sec_start[ADDR_W-1:0];
                                end_next   = ADDR_W'(sec_end - 32'd1);
                                state_next = ST_ERASE;
                            end
                            else
                            begin
                                pend_status_next = 1'b1;
                            end
                        end
                        ACT_ERASE_BULK:
                        begin
                            ptr_next   = '0;
                            end_next   = LAST_ADDR;
                            state_next = ST_ERASE;
                        end
                        default:
                        begin
                            pend_status_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // read data stays in the RAM output register while the result waits
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_rd_next     = is_prog_reg ? 8'h00 : ram_rdata;
                    out_status_next = 1'b0;
                    out_last_next   = pend_last_reg;
                    if (is_prog_reg)
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.addr  = addr_reg;
                        ram_req.wdata = ram_rdata & data_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_ERASE:
            begin
                ram_req.we = 1'b1;
                if (ptr_reg == end_reg)
                begin
                    ptr_next   = '0;
                    state_next = ST_RESULT;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_rd_next     = 8'h00;
                    out_status_next = pend_status_reg;
                    out_last_next   = pend_last_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg         <= end_next;
        addr_reg        <= addr_next;
        data_reg        <= data_next;
        is_prog_reg     <= is_prog_next;
        pend_status_reg <= pend_status_next;
        pend_last_reg   <= pend_last_next;
        out_rd_reg      <= out_rd_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_rd_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.last      = out_last_reg;

    assign stat.clearing = (state_reg == ST_CLEAR);
    assign stat.walking  = (state_reg == ST_ERASE) || (state_reg == ST_CLEAR);

endmodule

### rtl/nor_flash_array_model.sv
// Top level of the byte-wide NOR flash array model: sequencer plus array RAM.
// Depends on nfa_pkg, nfa_req_if, nfa_rsp_if, nfa_ram, nfa_ctrl and the assert header.
//
// Usage:
//   req carries one action beat: read byte, program byte (AND into the array),
//   subsector erase, sector erase or bulk erase. rsp returns exactly one beat per
//   request: read_data (zero unless a good read), status (1 on a bad address,
//   block number or action) and last, a copy of burst_last.
//   One request is in flight at a time. Read and program issue the array read at
//   accept, then load the result register (and write back the ANDed byte on
//   program). An error or unknown action goes straight to loading the result
//   register. An erase walks the region one byte per cycle through the single
//   RAM port, then loads the result register; any load waits while rsp stalls.
//   After reset the block runs a clearing pass that writes 0xFF to every byte
//   (FLASH_BYTES, 65536 bytes), with req.ready low throughout.
//   The result register parts the two sides: a request is accepted while an
//   earlier result waits; if rsp stalls, the next result holds in its final
//   state (read data held in the RAM output register) until the beat drains.
`include "nor_flash_array_model_assert.svh"

module nor_flash_array_model
    import nfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    nfa_req_if.sink   req,
    nfa_rsp_if.source rsp
);

    ram_req_t   ram_req;
    logic [7:0] ram_rdata;
    stat_t      stat;

    // decode, walk and result handling
    nfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .stat      (stat)
    );

    // the flash array itself
    nfa_ram #(
        .DEPTH (FLASH_BYTES),
        .WIDTH (8)
    ) u_array (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    // no request may enter during the clearing pass
    `NFA_ASSERT_SAME(a_no_accept_clear, clk, rst_n, stat.clearing, !req.ready)
    // one request in flight: an accept closes the input side for the next cycle
    `NFA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req.valid && req.ready, !req.ready)
    // a walk only ever writes the erased value
    `NFA_ASSERT_SAME(a_walk_erased, clk, rst_n, stat.walking && ram_req.we,
                     ram_req.wdata == ERASED_BYTE)

endmodule
